/* design/bitmap_font_text_rasterizer_top_defines.svh */
// Assertion macros shared by the text rasterizer modules.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef BITMAP_FONT_TEXT_RASTERIZER_TOP_DEFINES_SVH
`define BITMAP_FONT_TEXT_RASTERIZER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BFTR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BFTR_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define BFTR_ASSERT(label, prop, msg)
`define BFTR_ASSERT_NEVER(label, cond, msg)
`endif
`endif

/* design/bftr_pkg.sv */
// Shared types and constants of the text rasterizer: glyph job record and font ROM.
// No dependencies.
package bftr_pkg;

	localparam int GLYPH_BITS = 24;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_FIRST = 8'h20;
	localparam logic [7:0] CHAR_MULTI = 8'h80;
	localparam logic [7:0] LEAD_TWO = 8'hC0;
	localparam logic [7:0] LEAD_THREE = 8'hE0;
	localparam logic [7:0] LEAD_FOUR = 8'hF0;
	localparam logic signed [12:0] COORD_MAX = 13'sd2047;
	localparam logic signed [12:0] GLYPH_ADVANCE = 13'sd5;
	localparam logic signed [12:0] LINE_ADVANCE = 13'sd8;
	localparam logic [15:0] OPAQUE_BIT = 16'h8000;

	typedef struct packed {
		logic [GLYPH_BITS-1:0] mask;
		logic [7:0] x;
		logic [7:0] y;
		logic [15:0] color;
	} glyph_job_t;

	localparam logic [23:0] FONT_ROM [96] = '{
		24'h000000, 24'h444040, 24'hAA0000, 24'h5F5F50,
		24'h6EC760, 24'h936490, 24'h4A4AD0, 24'h440000,
		24'h244420, 24'h422240, 24'h0A4A00, 24'h04E400,
		24'h000024, 24'h00E000, 24'h000040, 24'h124480,
		24'h69BD96, 24'h262227, 24'h69248F, 24'hE1611E,
		24'h99F111, 24'hF8E11E, 24'h68E996, 24'hF12444,
		24'h696996, 24'h699716, 24'h040400, 24'h040424,
		24'h124842, 24'h0E0E00, 24'h421248, 24'h692020,
		24'h6BDB87, 24'h699F99, 24'hE9E99E, 24'h698896,
		24'hE9999E, 24'hF8E88F, 24'hF8E888, 24'h698B96,
		24'h99F999, 24'hE4444E, 24'h711196, 24'h9ACA99,
		24'h88888F, 24'h9FF999, 24'h9DBB99, 24'h699996,
		24'hE99E88, 24'h699B95, 24'hE99EA9, 24'h69861E,
		24'hE44444, 24'h999996, 24'h999966, 24'h999FF9,
		24'h996999, 24'h996444, 24'hF1248F, 24'h644446,
		24'h844221, 24'h622226, 24'h690000, 24'h00000F,
		24'h420000, 24'h699F99, 24'hE9E99E, 24'h698896,
		24'hE9999E, 24'hF8E88F, 24'hF8E888, 24'h698B96,
		24'h99F999, 24'hE4444E, 24'h711196, 24'h9ACA99,
		24'h88888F, 24'h9FF999, 24'h9DBB99, 24'h699996,
		24'hE99E88, 24'h699B95, 24'hE99EA9, 24'h69861E,
		24'hE44444, 24'h999996, 24'h999966, 24'h999FF9,
		24'h996999, 24'h996444, 24'hF1248F, 24'h248442,
		24'h444444, 24'h421424, 24'h05A000, 24'h000000
	};

endpackage

/* design/bftr_in_if.sv */
// Input channel of the text rasterizer: one text byte per transfer.
// No dependencies.
interface bftr_in_if;
	logic valid;
	logic ready;
	logic [7:0] text_byte;
	logic start_of_text;
	logic signed [11:0] origin_x;
	logic signed [11:0] origin_y;
	logic [15:0] ink_color;

	modport source (output valid, text_byte, start_of_text, origin_x, origin_y, ink_color,
		input ready);
	modport sink (input valid, text_byte, start_of_text, origin_x, origin_y, ink_color,
		output ready);
endinterface

/* design/bftr_out_if.sv */
// Output channel of the text rasterizer: one framebuffer pixel write per transfer.
// No dependencies.
interface bftr_out_if;
	logic valid;
	logic ready;
	logic [7:0] pixel_x;
	logic [7:0] pixel_y;
	logic [15:0] pixel_color;
	logic last_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

/* design/bftr_front.sv */
// Front end: takes text bytes, tracks cursor and UTF-8 skipping, builds clipped glyph jobs.
// Depends on bftr_pkg and bftr_in_if.
module bftr_front import bftr_pkg::*; #(
	parameter int SCREEN_WIDTH = 240,
	parameter int SCREEN_HEIGHT = 160
) (
	input  logic clk,
	input  logic arst_n,
	bftr_in_if.sink in_ch,
	input  logic queue_full,
	output logic push,
	output glyph_job_t push_job
);

	localparam logic signed [12:0] WIDTH_LIM = 13'(SCREEN_WIDTH);
	localparam logic signed [12:0] HEIGHT_LIM = 13'(SCREEN_HEIGHT);

	logic signed [11:0] cursor_x_q, cursor_y_q, line_start_x_q;
	logic [1:0] skip_q;

	logic accept, start, skipping, is_multi, is_newline, is_glyph;
	logic signed [11:0] cx, cy, lsx;
	logic signed [12:0] x_adv, y_adv;
	logic signed [11:0] x_adv_sat, y_adv_sat;
	logic [6:0] rom_idx;
	logic [23:0] glyph;
	logic [3:0] col_vis;
	logic [5:0] row_vis;
	logic [23:0] vis_mask;
	logic signed [12:0] px, py;
	logic [1:0] skip_new;

	assign in_ch.ready = !queue_full;
	assign accept = in_ch.valid && in_ch.ready;
	assign start = in_ch.start_of_text;
	assign skipping = !start && (skip_q != 2'd0);
	assign cx = start ? in_ch.origin_x : cursor_x_q;
	assign cy = start ? in_ch.origin_y : cursor_y_q;
	assign lsx = start ? in_ch.origin_x : line_start_x_q;
	assign is_multi = in_ch.text_byte >= CHAR_MULTI;
	assign is_newline = in_ch.text_byte == CHAR_NEWLINE;
	assign is_glyph = !is_multi && (in_ch.text_byte >= CHAR_FIRST);

	assign x_adv = 13'(cx) + GLYPH_ADVANCE;
	assign y_adv = 13'(cy) + LINE_ADVANCE;
	assign x_adv_sat = (x_adv > COORD_MAX) ? 12'(COORD_MAX) : x_adv[11:0];
	assign y_adv_sat = (y_adv > COORD_MAX) ? 12'(COORD_MAX) : y_adv[11:0];

	assign rom_idx = is_glyph ? 7'(in_ch.text_byte[6:0] - 7'(CHAR_FIRST)) : 7'd0;
	assign glyph = FONT_ROM[rom_idx];

	always_comb begin
		px = '0;
		py = '0;
		for (int c = 0; c < 4; c++) begin
			px = 13'(cx) + 13'(c);
			col_vis[c] = !px[12] && (px < WIDTH_LIM);
		end
		for (int r = 0; r < 6; r++) begin
			py = 13'(cy) + 13'(r);
			row_vis[r] = !py[12] && (py < HEIGHT_LIM);
		end
		for (int i = 0; i < 24; i++) begin
			vis_mask[23 - i] = glyph[23 - i] && col_vis[i % 4] && row_vis[i / 4];
		end
	end

	always_comb begin
		if (in_ch.text_byte >= LEAD_FOUR) begin
			skip_new = 2'd3;
		end else if (in_ch.text_byte >= LEAD_THREE) begin
			skip_new = 2'd2;
		end else if (in_ch.text_byte >= LEAD_TWO) begin
			skip_new = 2'd1;
		end else begin
			skip_new = 2'd0;
		end
	end

	assign push = accept && !skipping && is_glyph && (vis_mask != '0);
	assign push_job = '{mask: vis_mask, x: cx[7:0], y: cy[7:0],
		color: in_ch.ink_color | OPAQUE_BIT};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			line_start_x_q <= '0;
			skip_q <= '0;
		end else if (accept) begin
			if (skipping) begin
				skip_q <= skip_q - 2'd1;
			end else begin
				line_start_x_q <= lsx;
				skip_q <= is_multi ? skip_new : 2'd0;
				if (is_multi) begin
					cursor_x_q <= cx;
					cursor_y_q <= cy;
				end else if (is_newline) begin
					cursor_x_q <= lsx;
					cursor_y_q <= y_adv_sat;
				end else begin
					cursor_x_q <= x_adv_sat;
					cursor_y_q <= cy;
				end
			end
		end
	end

endmodule

/* design/bftr_fifo.sv */
// Short queue of glyph jobs between front end and pixel sequencer.
// Depends on bftr_pkg and the assertion macro header.
`include "bitmap_font_text_rasterizer_top_defines.svh"
module bftr_fifo import bftr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  glyph_job_t push_job,
	input  logic pop,
	output glyph_job_t head_job,
	output logic full,
	output logic empty
);

	glyph_job_t store_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0] count_q;

	assign full = count_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head_job = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
		end
	end

	`BFTR_ASSERT_NEVER(a_no_overflow, push && full, "glyph queue written while full")
	`BFTR_ASSERT_NEVER(a_no_underflow, pop && empty, "glyph queue read while empty")

endmodule

/* design/bftr_back.sv */
// Back end: walks the visible bits of one glyph job and emits one pixel write per cycle while out_ch.ready is high.
// Depends on bftr_pkg, bftr_out_if and the assertion macro header.
`include "bitmap_font_text_rasterizer_top_defines.svh"
module bftr_back import bftr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  glyph_job_t head_job,
	input  logic queue_empty,
	output logic pop,
	bftr_out_if.source out_ch
);

	logic [GLYPH_BITS-1:0] mask_q;
	logic [7:0] x_q, y_q;
	logic [15:0] color_q;

	logic [GLYPH_BITS-1:0] sel;
	logic [4:0] pos;
	logic last, xfer;

	always_comb begin
		sel = '0;
		pos = '0;
		for (int i = 0; i < GLYPH_BITS; i++) begin
			if (mask_q[i]) begin
				sel = '0;
				sel[i] = 1'b1;
				pos = 5'(GLYPH_BITS - 1 - i);
			end
		end
	end

	assign last = (mask_q & ~sel) == '0;
	assign xfer = out_ch.valid && out_ch.ready;
	assign pop = !queue_empty && ((mask_q == '0) || (xfer && last));

	assign out_ch.valid = mask_q != '0;
	assign out_ch.pixel_x = x_q + {6'd0, pos[1:0]};
	assign out_ch.pixel_y = y_q + {5'd0, pos[4:2]};
	assign out_ch.pixel_color = color_q;
	assign out_ch.last_pixel = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (pop) begin
			mask_q <= head_job.mask;
		end else if (xfer) begin
			mask_q <= mask_q & ~sel;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_q <= head_job.x;
			y_q <= head_job.y;
			color_q <= head_job.color;
		end
	end

	`BFTR_ASSERT(a_last_single_bit, (out_ch.valid && out_ch.last_pixel) |-> $onehot(mask_q), "last pixel flagged with more bits pending")
	`BFTR_ASSERT(a_stall_holds_mask, (out_ch.valid && !out_ch.ready) |=> $stable(mask_q), "pixel mask changed during output stall")

endmodule

/* design/bitmap_font_text_rasterizer_top.sv */
// Text rasterizer with a built-in 4x6 font: bytes in, clipped framebuffer pixel writes out.
// Depends on bftr_pkg, bftr_in_if, bftr_out_if, bftr_front, bftr_fifo and bftr_back.
//
// The front end takes one text byte per cycle, updates the cursor and the UTF-8 skip
// count at once and, for a printable character with on-screen pixels, queues a glyph job
// whose mask already holds only the lit, visible pixels. The back end emits one pixel
// write per cycle while the output is ready, from jobs popped off a four-entry queue,
// so a byte that lights n visible pixels gives n pixel writes (1 to 24), and the
// sequencer moves from one glyph to the next without a gap when the next job is
// queued. Bytes that draw nothing (newline, control codes, skipped or multi-byte UTF-8
// bytes, glyphs wholly off screen) stay in the front end and never reach the queue.
// The input stalls only while the queue is full. No clearing pass is needed after reset.
module bitmap_font_text_rasterizer_top import bftr_pkg::*; #(
	parameter int SCREEN_WIDTH = 240,
	parameter int SCREEN_HEIGHT = 160
) (
	input  logic clk,
	input  logic arst_n,
	bftr_in_if.sink in_ch,
	bftr_out_if.source out_ch
);

	logic push, pop, full, empty;
	glyph_job_t push_job, head_job;

	bftr_front #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.queue_full(full),
		.push(push),
		.push_job(push_job)
	);

	bftr_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.head_job(head_job),
		.full(full),
		.empty(empty)
	);

	bftr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_job(head_job),
		.queue_empty(empty),
		.pop(pop),
		.out_ch(out_ch)
	);

endmodule
